@@ rtl/fpr_pkg.sv @@
// Shared types, constants and codes of the framed packet receiver.
`default_nettype none
package fpr_pkg;

  // Frame length in bytes, header and end byte included.
  localparam int unsigned FRAME_LEN = 8;

  // Byte counter width and the depth of the frame byte store.
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned STORE_DEPTH = 8;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  // Frame positions that are decoded.
  localparam int unsigned POS_COLOR = 2;
  localparam int unsigned POS_X_HI  = 3;
  localparam int unsigned POS_X_LO  = 4;
  localparam int unsigned POS_Y_HI  = 5;
  localparam int unsigned POS_Y_LO  = 6;

  // Marker bytes.
  localparam logic [7:0] HDR_FIRST  = 8'h1D;
  localparam logic [7:0] HDR_SECOND = 8'hD1;
  localparam logic [7:0] END_BYTE   = 8'hED;

  // Colour bytes.
  localparam logic [7:0] COL_RED_BYTE   = 8'hFF;
  localparam logic [7:0] COL_GREEN_BYTE = 8'h3F;
  localparam logic [7:0] COL_BLUE_BYTE  = 8'h0F;

  // Colour codes on the result.
  localparam logic [1:0] COLOR_RED   = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;
  localparam logic [1:0] COLOR_NONE  = 2'd3;

  // Recognizer phases.
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR2 = 2'd1,
    PH_DATA = 2'd2,
    PH_END  = 2'd3
  } phase_e;

  // One finished frame as handed from the front end to the back end.
  typedef struct packed {
    logic        ok;
    logic [7:0]  color_byte;
    logic [15:0] x_offset;
    logic [15:0] y_offset;
  } frame_rec_t;

endpackage
`default_nettype wire

@@ rtl/fpr_front.sv @@
// Front end: accepts received bytes, tracks the frame phase and stores payload bytes.
`default_nettype none
module fpr_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output fpr_pkg::frame_rec_t      rec_o
);

  fpr_pkg::phase_e              phase_q, phase_d;
  logic [fpr_pkg::CNT_W-1:0]    byte_count_q, byte_count_d;
  logic [7:0]                   store_q [fpr_pkg::STORE_DEPTH];
  logic                         accept;
  logic                         store_we;
  logic [fpr_pkg::CNT_W-1:0]    count_inc;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign count_inc  = byte_count_q + fpr_pkg::CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= fpr_pkg::PH_HUNT;
      byte_count_q <= '0;
    end else begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
    end
  end

  // Bytes past the store depth are payload that is never decoded.
  always_ff @(posedge clk_i) begin
    if (store_we && (byte_count_q < fpr_pkg::CNT_W'(fpr_pkg::STORE_DEPTH))) begin
      store_q[byte_count_q[fpr_pkg::STORE_AW-1:0]] <= rx_byte_i;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    store_we     = 1'b0;
    push_o       = 1'b0;
    if (accept) begin
      unique case (phase_q)
        fpr_pkg::PH_HUNT: begin
          if (rx_byte_i == fpr_pkg::HDR_FIRST) begin
            store_we     = 1'b1;
            byte_count_d = count_inc;
            phase_d      = fpr_pkg::PH_HDR2;
          end else begin
            byte_count_d = '0;
          end
        end
        fpr_pkg::PH_HDR2: begin
          if (rx_byte_i == fpr_pkg::HDR_SECOND) begin
            store_we     = 1'b1;
            byte_count_d = count_inc;
            phase_d      = fpr_pkg::PH_DATA;
          end else begin
            byte_count_d = '0;
            phase_d      = fpr_pkg::PH_HUNT;
          end
        end
        fpr_pkg::PH_DATA: begin
          store_we     = 1'b1;
          byte_count_d = count_inc;
          if (count_inc >= fpr_pkg::CNT_W'(fpr_pkg::FRAME_LEN - 1)) begin
            phase_d = fpr_pkg::PH_END;
          end
        end
        fpr_pkg::PH_END: begin
          push_o       = 1'b1;
          byte_count_d = '0;
          phase_d      = fpr_pkg::PH_HUNT;
        end
        default: begin
          phase_d = fpr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  assign rec_o.ok         = (rx_byte_i == fpr_pkg::END_BYTE);
  assign rec_o.color_byte = store_q[fpr_pkg::POS_COLOR];
  assign rec_o.x_offset   = {store_q[fpr_pkg::POS_X_HI], store_q[fpr_pkg::POS_X_LO]};
  assign rec_o.y_offset   = {store_q[fpr_pkg::POS_Y_HI], store_q[fpr_pkg::POS_Y_LO]};

endmodule
`default_nettype wire

@@ rtl/fpr_fifo.sv @@
// Two-entry queue of finished frame records between front end and back end.
`default_nettype none
module fpr_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire fpr_pkg::frame_rec_t  data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output fpr_pkg::frame_rec_t       data_o,
  output logic                      empty_o
);

  fpr_pkg::frame_rec_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/fpr_back.sv @@
// Back end: decodes the colour byte, keeps the last colour and holds the result register.
`default_nettype none
module fpr_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire fpr_pkg::frame_rec_t  rec_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      frame_ok_o,
  output logic [1:0]                color_code_o,
  output logic                      color_known_o,
  output logic [15:0]               x_offset_o,
  output logic [15:0]               y_offset_o
);

  logic        valid_q;
  logic [1:0]  last_color_q, last_color_d;
  logic        ok_q, known_q, known_d;
  logic [15:0] x_q, y_q;

  assign pop_o = !q_empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    last_color_d = last_color_q;
    known_d      = 1'b0;
    if (rec_i.ok) begin
      known_d = 1'b1;
      unique case (rec_i.color_byte)
        fpr_pkg::COL_RED_BYTE:   last_color_d = fpr_pkg::COLOR_RED;
        fpr_pkg::COL_GREEN_BYTE: last_color_d = fpr_pkg::COLOR_GREEN;
        fpr_pkg::COL_BLUE_BYTE:  last_color_d = fpr_pkg::COLOR_BLUE;
        default:                 known_d      = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      last_color_q <= fpr_pkg::COLOR_NONE;
    end else begin
      if (pop_o) begin
        valid_q      <= 1'b1;
        last_color_q <= last_color_d;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ok_q    <= rec_i.ok;
      known_q <= known_d;
      x_q     <= rec_i.ok ? rec_i.x_offset : 16'd0;
      y_q     <= rec_i.ok ? rec_i.y_offset : 16'd0;
    end
  end

  assign out_valid_o   = valid_q;
  assign frame_ok_o    = ok_q;
  assign color_code_o  = last_color_q;
  assign color_known_o = known_q;
  assign x_offset_o    = x_q;
  assign y_offset_o    = y_q;

endmodule
`default_nettype wire

@@ rtl/framed_packet_receiver.sv @@
// Top level of the framed packet receiver: front end, record queue and back end.
//
//  Channel  Valid        Stall        Payload
//  input    in_valid_i   in_stall_o   rx_byte_i
//  output   out_valid_o  out_stall_i  frame_ok_o, color_code_o, color_known_o,
//                                     x_offset_o, y_offset_o
//
// One received byte is taken every clock while the record queue has room; the
// phase recognizer in the front end advances with each accepted byte.
// Once the end byte is accepted, its record is written into the queue and then
// loaded into the result register, which offers it until it is taken.
// Reset is asynchronous and active low; it clears the phase, byte count,
// queue pointers, result valid and sets the last colour to none seen.
// Output stalls back up into the two-entry queue; input stalls only once that
// queue is full, so bytes that end no frame keep flowing until then.
`default_nettype none
module framed_packet_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             frame_ok_o,
  output logic [1:0]       color_code_o,
  output logic             color_known_o,
  output logic [15:0]      x_offset_o,
  output logic [15:0]      y_offset_o
);

  // Record handoff between the front end and the queue.
  logic                push;
  logic                q_full;
  fpr_pkg::frame_rec_t push_rec;

  // Record handoff between the queue and the back end.
  logic                pop;
  logic                q_empty;
  fpr_pkg::frame_rec_t pop_rec;

  // The front end recognizes headers, counts bytes and stores the payload. At
  // the end position it emits one record, good or bad, into the queue.
  fpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  // The queue decouples byte intake from result delivery.
  fpr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_rec),
    .empty_o (q_empty)
  );

  // The back end maps the colour byte, keeps the last known colour in record
  // order and drives the registered result.
  fpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .rec_i         (pop_rec),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_ok_o    (frame_ok_o),
    .color_code_o  (color_code_o),
    .color_known_o (color_known_o),
    .x_offset_o    (x_offset_o),
    .y_offset_o    (y_offset_o)
  );

  // The front end never writes a record into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_full))
    else $error("record pushed into a full queue");

  // The back end never takes a record from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && q_empty))
    else $error("record popped from an empty queue");

  // A frame without its end byte reports no colour and zero offsets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_ok_o) |->
      (!color_known_o && (x_offset_o == 16'd0) && (y_offset_o == 16'd0)))
    else $error("bad frame result carries data");

  // A recognized colour is always a real colour code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && color_known_o) |-> (color_code_o != fpr_pkg::COLOR_NONE))
    else $error("known colour reported as none");

endmodule
`default_nettype wire
